[hw/rtl/averaged_reference_sad_unit_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the averaged reference SAD unit
// Concurrent checks clocked on the rising edge, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef AVERAGED_REFERENCE_SAD_UNIT_DEFINES_SVH
`define AVERAGED_REFERENCE_SAD_UNIT_DEFINES_SVH

// Property that must hold in the same cycle.
`define ARSAD_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define ARSAD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/arsad_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arsad_pkg
// Shared widths, register indices, reset values and the queue word type.
// ----------------------------------------------------------------------------
package arsad_pkg;

	localparam int LANES                = 8;
	localparam int PIX_W                = 8;
	localparam int GROUP_W              = LANES * PIX_W;
	localparam int SUM_W                = 21;
	localparam int GRP_CNT_W            = 3;
	localparam int WIDTH_REG_W          = 4;
	localparam int HEIGHT_REG_W         = 8;
	localparam int CFG_IDX_W            = 2;
	localparam int CFG_DATA_W           = 8;
	localparam int MAX_GROUPS           = 8;
	localparam int DEF_MAX_BLOCK_HEIGHT = 128;
	localparam int DEF_QUEUE_DEPTH      = 2;

	localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 4'd8;
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 8'd64;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WIDTH_GROUPS = 2'd0,
		CFG_BLOCK_HEIGHT = 2'd1
	} cfg_index_t;

	// one queued word: the pixel group plus its end-of-block mark
	typedef struct packed {
		logic [GROUP_W-1:0] src;
		logic [GROUP_W-1:0] ref_a;
		logic [GROUP_W-1:0] ref_b;
		logic               last;
	} word_t;

endpackage
`default_nettype wire

[hw/rtl/arsad_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arsad_front
// Takes input words, holds the configuration and the group/row counters,
// and marks the word that closes a block before queueing it.
// ----------------------------------------------------------------------------
module arsad_front
	import arsad_pkg::*;
#(
	parameter int MAX_BLOCK_HEIGHT = DEF_MAX_BLOCK_HEIGHT
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [GROUP_W-1:0]    source_pixels,
	input  wire logic [GROUP_W-1:0]    first_ref_pixels,
	input  wire logic [GROUP_W-1:0]    second_ref_pixels,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  queue_full,
	output logic                       push,
	output word_t                      push_word
);

	localparam int ROW_W = $clog2(MAX_BLOCK_HEIGHT);
	localparam int CMP_W = HEIGHT_REG_W + 1;
	localparam logic [CMP_W-1:0] MAX_H = CMP_W'(MAX_BLOCK_HEIGHT);
	localparam logic [WIDTH_REG_W-1:0] MAX_G = WIDTH_REG_W'(MAX_GROUPS);

	logic [WIDTH_REG_W-1:0]  width_q;
	logic [HEIGHT_REG_W-1:0] height_q;
	logic [GRP_CNT_W-1:0]    grp_q;
	logic [ROW_W-1:0]        row_q;

	logic [WIDTH_REG_W-1:0] eff_g;
	logic [CMP_W-1:0]       eff_h;
	logic [CMP_W-1:0]       height_ext;
	logic [WIDTH_REG_W-1:0] grp_next;
	logic [CMP_W-1:0]       row_next;
	logic                   row_more;
	logic                   blk_more;

	assign in_ready  = !queue_full;
	assign cfg_ready = 1'b1;
	assign push      = in_valid && in_ready;

	// out-of-range settings are clamped
	assign height_ext = CMP_W'(height_q);
	always_comb begin
		if (width_q == '0) begin
			eff_g = WIDTH_REG_W'(1);
		end else if (width_q > MAX_G) begin
			eff_g = MAX_G;
		end else begin
			eff_g = width_q;
		end
		if (height_q == '0) begin
			eff_h = CMP_W'(1);
		end else if (height_ext > MAX_H) begin
			eff_h = MAX_H;
		end else begin
			eff_h = height_ext;
		end
	end

	assign grp_next = WIDTH_REG_W'(grp_q) + WIDTH_REG_W'(1);
	assign row_next = CMP_W'(row_q) + CMP_W'(1);
	assign row_more = grp_next < eff_g;
	assign blk_more = row_next < eff_h;

	assign push_word.src   = source_pixels;
	assign push_word.ref_a = first_ref_pixels;
	assign push_word.ref_b = second_ref_pixels;
	assign push_word.last  = !row_more && !blk_more;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_WIDTH_GROUPS: width_q  <= cfg_data[WIDTH_REG_W-1:0];
				CFG_BLOCK_HEIGHT: height_q <= cfg_data[HEIGHT_REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_q <= '0;
			row_q <= '0;
		end else if (push) begin
			if (row_more) begin
				grp_q <= grp_next[GRP_CNT_W-1:0];
			end else begin
				grp_q <= '0;
				if (blk_more) begin
					row_q <= row_next[ROW_W-1:0];
				end else begin
					row_q <= '0;
				end
			end
		end
	end

endmodule
`default_nettype wire

[hw/rtl/arsad_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arsad_fifo
// Short register queue between the front and back; first-word fall-through.
// ----------------------------------------------------------------------------
module arsad_fifo
	import arsad_pkg::*;
#(
	parameter int WIDTH = $bits(word_t),
	parameter int DEPTH = DEF_QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic                  not_empty,
	output logic [WIDTH-1:0]      pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = count_q == CNT_W'(DEPTH);
	assign not_empty = count_q != '0;
	assign pop_data  = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

[hw/rtl/arsad_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arsad_back
// Lane stage (rounded average, absolute difference), then an adder tree into
// the running sum; the closing word loads the result register.
// ----------------------------------------------------------------------------
module arsad_back
	import arsad_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        q_valid,
	input  word_t            q_word,
	output logic             pop,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [SUM_W-1:0] block_sad
);

	localparam int GSAD_W = PIX_W + $clog2(LANES);

	logic [PIX_W-1:0] diff_s1 [LANES];
	logic             valid_s1;
	logic             last_s1;
	logic [PIX_W-1:0] diff_d  [LANES];

	logic [SUM_W-1:0]  acc_q;
	logic [SUM_W-1:0]  out_q;
	logic              out_valid_q;
	logic [GSAD_W-1:0] gsad;
	logic [SUM_W-1:0]  acc_sum;
	logic              fire_acc;
	logic              adv_s1;

	// lane stage
	always_comb begin
		logic [PIX_W:0]   pair;
		logic [PIX_W-1:0] avg;
		logic [PIX_W-1:0] sp;
		for (int l = 0; l < LANES; l++) begin
			sp   = q_word.src[l*PIX_W +: PIX_W];
			pair = {1'b0, q_word.ref_a[l*PIX_W +: PIX_W]}
				+ {1'b0, q_word.ref_b[l*PIX_W +: PIX_W]} + (PIX_W+1)'(1);
			avg  = pair[PIX_W:1];
			diff_d[l] = (sp > avg) ? (sp - avg) : (avg - sp);
		end
	end

	// a closing word waits while the result register is still occupied
	assign fire_acc = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign adv_s1   = !valid_s1 || fire_acc;
	assign pop      = q_valid && adv_s1;

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			diff_s1 <= diff_d;
			last_s1 <= q_word.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= q_valid;
		end
	end

	always_comb begin
		gsad = '0;
		for (int l = 0; l < LANES; l++) begin
			gsad = gsad + GSAD_W'(diff_s1[l]);
		end
	end

	assign acc_sum = acc_q + SUM_W'(gsad);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire_acc) begin
				acc_q <= last_s1 ? '0 : acc_sum;
			end
			if (fire_acc && last_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire_acc && last_s1) begin
			out_q <= acc_sum;
		end
	end

	assign out_valid = out_valid_q;
	assign block_sad = out_q;

endmodule
`default_nettype wire

[hw/rtl/averaged_reference_sad_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// averaged_reference_sad_unit
// Block SAD between a source block and the rounded average of two references.
// ----------------------------------------------------------------------------
//
//  channel  handshake            payload                                word
//  -------  -------------------  -------------------------------------  -----
//  in       in_valid/in_ready    source/first_ref/second_ref_pixels     group
//  out      out_valid/out_ready  block_sad                              total
//  cfg      cfg_valid/cfg_ready  cfg_index, cfg_data                    write
//
//  One input word per cycle, sustained while no held result stalls a closing
//  word; the lane stage and the single accumulator both take a new group every cycle.
//  The closing input word is queued at acceptance, then registered in the
//  lane stage, then its total loads the result register and block_sad valid.
//  Reset clears counters, sum and valids; config returns to 8 groups x 64 rows.
//  A held result stalls only a closing word in the lane stage; behind it the
//  queue takes QUEUE_DEPTH more words, then in_ready drops until the result
//  is taken.
//  cfg_ready is always high.
//
module averaged_reference_sad_unit
	import arsad_pkg::*;
#(
	parameter int MAX_BLOCK_HEIGHT = DEF_MAX_BLOCK_HEIGHT,
	parameter int QUEUE_DEPTH      = DEF_QUEUE_DEPTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [GROUP_W-1:0]    source_pixels,
	input  wire logic [GROUP_W-1:0]    first_ref_pixels,
	input  wire logic [GROUP_W-1:0]    second_ref_pixels,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [SUM_W-1:0]           block_sad,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	// front to queue
	logic  push;
	word_t push_word;
	logic  queue_full;

	// queue to back
	logic  q_valid;
	word_t q_word;
	logic  pop;

	arsad_front #(
		.MAX_BLOCK_HEIGHT(MAX_BLOCK_HEIGHT)
	) u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.source_pixels     (source_pixels),
		.first_ref_pixels  (first_ref_pixels),
		.second_ref_pixels (second_ref_pixels),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.queue_full        (queue_full),
		.push              (push),
		.push_word         (push_word)
	);

	// the word carries its own end-of-block mark, so the back needs no counters
	arsad_fifo #(
		.WIDTH($bits(word_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_word),
		.full      (queue_full),
		.pop       (pop),
		.not_empty (q_valid),
		.pop_data  (q_word)
	);

	arsad_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_word    (q_word),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.block_sad (block_sad)
	);

endmodule
`default_nettype wire

[hw/rtl/arsad_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arsad_checker
// Port-level checks on the SAD unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "averaged_reference_sad_unit_defines.svh"

module arsad_checker
	import arsad_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  in_ready,
	input wire logic                  out_valid,
	input wire logic                  out_ready,
	input wire logic [SUM_W-1:0]      block_sad
);

	// no result can be ready in the first cycle out of reset
	`ARSAD_ASSERT(a_no_early_out, clk, arst_n, $past(!arst_n) |-> !out_valid, "result straight out of reset")

	// with the result register free the back drains, so the queue has room next cycle
	`ARSAD_ASSERT_NEXT(a_drain_ready, clk, arst_n, !out_valid, in_ready, "input stalled with free output")

	`ARSAD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped")

	`ARSAD_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(block_sad), "result changed while held")

endmodule

bind averaged_reference_sad_unit arsad_checker u_checker (.*);
`default_nettype wire

[tb/block_sad_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_sad_checker
// Watches the group, total and register channels of the averaged reference
// SAD unit, predicts each block total and compares it with the one returned.
// ----------------------------------------------------------------------------
module block_sad_checker
	import arsad_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire logic                  in_ready,
	input  wire logic [GROUP_W-1:0]    source_pixels,
	input  wire logic [GROUP_W-1:0]    first_ref_pixels,
	input  wire logic [GROUP_W-1:0]    second_ref_pixels,
	input  wire logic                  out_valid,
	input  wire logic                  out_ready,
	input  wire logic [SUM_W-1:0]      block_sad,
	input  wire logic                  cfg_valid,
	input  wire logic                  cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output int                         pending_results,
	output int                         mismatch_count
);

	logic [WIDTH_REG_W-1:0]  width_reg;
	logic [HEIGHT_REG_W-1:0] height_reg;
	logic [SUM_W-1:0]        sum_acc;
	int unsigned             group_idx;
	int unsigned             row_idx;
	int                      fails;
	logic [SUM_W-1:0]        expected_totals[$];

	// SAD of one eight-pixel word against the rounded pair average
	function automatic logic [SUM_W-1:0] group_abs_diff(input logic [GROUP_W-1:0] s,
			input logic [GROUP_W-1:0] a, input logic [GROUP_W-1:0] b);
		logic [SUM_W-1:0] total;
		logic [PIX_W:0]   avg;
		logic [PIX_W:0]   sp;
		total = '0;
		for (int lane = 0; lane < LANES; lane++) begin
			sp  = {1'b0, s[lane*PIX_W +: PIX_W]};
			avg = ({1'b0, a[lane*PIX_W +: PIX_W]} + b[lane*PIX_W +: PIX_W] + 1'b1) >> 1;
			total += (sp > avg) ? (sp - avg) : (avg - sp);
		end
		return total;
	endfunction

	function automatic int unsigned row_width_groups();
		if (width_reg == 0)
			return 1;
		if (width_reg > MAX_GROUPS)
			return MAX_GROUPS;
		return width_reg;
	endfunction

	function automatic int unsigned rows_per_block();
		if (height_reg == 0)
			return 1;
		if (height_reg > DEF_MAX_BLOCK_HEIGHT)
			return DEF_MAX_BLOCK_HEIGHT;
		return height_reg;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg  = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
			sum_acc    = '0;
			group_idx  = 0;
			row_idx    = 0;
			fails      = 0;
			expected_totals.delete();
			pending_results <= 0;
			mismatch_count  <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_WIDTH_GROUPS: width_reg  = cfg_data[WIDTH_REG_W-1:0];
					CFG_BLOCK_HEIGHT: height_reg = cfg_data[HEIGHT_REG_W-1:0];
					default: ;
				endcase
			end

			if (out_valid && out_ready) begin
				if (expected_totals.size() == 0) begin
					$error("block_sad: got %0d with no total expected", block_sad);
					fails++;
				end else if (block_sad !== expected_totals[0]) begin
					$error("block_sad: expected %0d, got %0d", expected_totals[0], block_sad);
					fails++;
					void'(expected_totals.pop_front());
				end else begin
					void'(expected_totals.pop_front());
				end
			end

			// counters are not cleared by a register write; a shrunk setting
			// closes the row or block on the next word
			if (in_valid && in_ready) begin
				sum_acc = sum_acc + group_abs_diff(source_pixels, first_ref_pixels,
						second_ref_pixels);
				if (group_idx + 1 < row_width_groups()) begin
					group_idx++;
				end else begin
					group_idx = 0;
					if (row_idx + 1 < rows_per_block()) begin
						row_idx++;
					end else begin
						expected_totals.push_back(sum_acc);
						sum_acc = '0;
						row_idx = 0;
					end
				end
			end

			pending_results <= expected_totals.size();
			mismatch_count  <= fails;
		end
	end

endmodule

[tb/averaged_reference_sad_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// averaged_reference_sad_unit_test
// Drives pixel words and register writes into the averaged reference SAD
// unit under varying back-pressure; a side checker predicts every block total.
// ----------------------------------------------------------------------------
module averaged_reference_sad_unit_test;
	import arsad_pkg::*;

	// closing word to block_sad valid, counted from acceptance
	localparam int RESULT_LATENCY = 2;
	// watchdog: far above the slowest legal run of this stimulus
	localparam int CYCLE_LIMIT    = 400000;
	// index codes the unit does not decode; writes there must change nothing
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LOW  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HIGH = 2'd3;

	logic                  clk               = 1'b0;
	logic                  arst_n            = 1'b0;
	logic                  in_valid          = 1'b0;
	logic                  in_ready;
	logic [GROUP_W-1:0]    source_pixels     = '0;
	logic [GROUP_W-1:0]    first_ref_pixels  = '0;
	logic [GROUP_W-1:0]    second_ref_pixels = '0;
	logic                  out_valid;
	logic                  out_ready         = 1'b0;
	logic [SUM_W-1:0]      block_sad;
	logic                  cfg_valid         = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index         = '0;
	logic [CFG_DATA_W-1:0] cfg_data          = '0;

	int pending_results;
	int mismatch_count;
	int cycle_count    = 0;
	// idle rates in percent: gaps before a word, stalls on the total channel
	int source_gap_pct = 0;
	int sink_stall_pct = 0;

	averaged_reference_sad_unit u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.source_pixels     (source_pixels),
		.first_ref_pixels  (first_ref_pixels),
		.second_ref_pixels (second_ref_pixels),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.block_sad         (block_sad),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data)
	);

	block_sad_checker u_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.source_pixels     (source_pixels),
		.first_ref_pixels  (first_ref_pixels),
		.second_ref_pixels (second_ref_pixels),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.block_sad         (block_sad),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.pending_results   (pending_results),
		.mismatch_count    (mismatch_count)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// total channel back-pressure, redrawn every cycle on the falling edge
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// watchdog: a hung handshake or a lost total ends up here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("averaged_reference_sad_unit_test: FAIL");
			$finish;
		end
	end

	// One pixel word. Valid may be held high across back-to-back words; an
	// idle gap drops it first. in_ready is read straight after the rising
	// edge, before the unit's own updates land.
	task automatic push_group(input logic [GROUP_W-1:0] s, input logic [GROUP_W-1:0] a,
			input logic [GROUP_W-1:0] b);
		@(negedge clk);
		while ($urandom_range(99) < source_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid          <= 1'b1;
		source_pixels     <= s;
		first_ref_pixels  <= a;
		second_ref_pixels <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Hold off until every predicted total is back, then give a word that
	// closes no block time to clear the queue and lane stage.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0)
			@(posedge clk);
		repeat (RESULT_LATENCY + 3) @(posedge clk);
	endtask

	// one register write; only ever issued after settle()
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// pixels at or next to the range ends, now and then anything
	function automatic logic [PIX_W-1:0] extreme_byte();
		case ($urandom_range(4))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h01;
			3: return 8'hFE;
			default: return 8'($urandom);
		endcase
	endfunction

	// Random traffic: each segment picks a setting (mostly small blocks, now
	// and then a zero or oversized register value), sends a few whole blocks,
	// and sometimes stops short so that the next setting lands mid-block.
	task automatic run_traffic(input int target);
		int                 sent;
		int                 r;
		int                 eff_w;
		int                 eff_h;
		int                 span;
		int                 n;
		int                 style;
		int                 av;
		int                 sp;
		logic [3:0]         wnib;
		logic [7:0]         hdata;
		logic [GROUP_W-1:0] s;
		logic [GROUP_W-1:0] a;
		logic [GROUP_W-1:0] b;
		sent = 0;
		while (sent < target) begin
			r = $urandom_range(39);
			if (r == 0) begin
				// tall, narrow block, height often past the clamp
				hdata = 8'($urandom_range(255, 128));
				wnib  = 4'd1;
			end else begin
				if (r < 4)
					hdata = 8'd0;
				else if (r < 8)
					hdata = 8'($urandom_range(20, 7));
				else
					hdata = 8'($urandom_range(6, 1));
				case ($urandom_range(11))
					0: wnib = 4'd0;
					1: wnib = 4'($urandom_range(15, 9));
					default: wnib = 4'($urandom_range(8, 1));
				endcase
			end
			eff_w = (wnib == 0) ? 1 : ((wnib > MAX_GROUPS) ? MAX_GROUPS : wnib);
			eff_h = (hdata == 0) ? 1 :
					((hdata > DEF_MAX_BLOCK_HEIGHT) ? DEF_MAX_BLOCK_HEIGHT : hdata);
			span  = eff_w * eff_h;
			n     = span * ((r == 0) ? 1 : $urandom_range(4, 1));
			if ($urandom_range(5) == 0)
				n = $urandom_range(n, 1);
			// the last segment stops at the word budget, block closed or not
			if (n > target - sent)
				n = target - sent;

			settle();
			// upper nibble of the width write is don't-care; keep it noisy
			write_reg(CFG_WIDTH_GROUPS, {4'($urandom), wnib});
			write_reg(CFG_BLOCK_HEIGHT, hdata);

			for (int i = 0; i < n; i++) begin
				style = $urandom_range(2);
				for (int lane = 0; lane < LANES; lane++) begin
					case (style)
						0: begin
							s[lane*PIX_W +: PIX_W] = 8'($urandom);
							a[lane*PIX_W +: PIX_W] = 8'($urandom);
							b[lane*PIX_W +: PIX_W] = 8'($urandom);
						end
						1: begin
							s[lane*PIX_W +: PIX_W] = extreme_byte();
							a[lane*PIX_W +: PIX_W] = extreme_byte();
							b[lane*PIX_W +: PIX_W] = extreme_byte();
						end
						default: begin
							// source within a few steps of the rounded average
							a[lane*PIX_W +: PIX_W] = 8'($urandom);
							b[lane*PIX_W +: PIX_W] = 8'($urandom);
							av = (int'(a[lane*PIX_W +: PIX_W]) +
									int'(b[lane*PIX_W +: PIX_W]) + 1) >> 1;
							sp = av + int'($urandom_range(6)) - 3;
							sp = (sp < 0) ? 0 : ((sp > 255) ? 255 : sp);
							s[lane*PIX_W +: PIX_W] = 8'(sp);
						end
					endcase
				end
				push_group(s, a, b);
				sent++;
				// occasional full drain mid-stream
				if ($urandom_range(149) == 0)
					settle();
			end
		end
	endtask

	initial begin
		// reset held from time zero, released on a falling edge
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		source_gap_pct = 21;
		sink_stall_pct = 48;

		// --- directed -------------------------------------------------------
		// Reset setting is 8 groups x 64 rows: three words leave the group
		// count at 3. Worst-case difference, source under the average, then
		// odd pair sums that round up (0+1 -> 1, FE+FF -> FF).
		push_group({8{8'hFF}}, {8{8'h00}}, {8{8'h00}});
		push_group({8{8'h00}}, {8{8'hFF}}, {8{8'hFF}});
		push_group(64'h0180_00FF_7F81_8000, 64'h00FE_01FE_7F80_0001,
				64'h0101_FFFF_8080_FF00);

		// width zero counts as one group, shrunk below the group count: the
		// next word closes the row
		settle();
		write_reg(CFG_WIDTH_GROUPS, 8'h00);
		push_group(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 64'h5555_AAAA_0F0F_F0F0);

		// height zero counts as one row, below the row count: the next word
		// closes the block and returns the five-word total
		settle();
		write_reg(CFG_BLOCK_HEIGHT, 8'h00);
		push_group(64'hAAAA_5555_F0F0_0F0F, 64'h0000_FFFF_0000_FFFF, 64'hFFFF_0000_FFFF_0000);

		// width register past eight (all data bits set) clamps to eight
		settle();
		write_reg(CFG_WIDTH_GROUPS, 8'hFF);
		write_reg(CFG_BLOCK_HEIGHT, 8'h02);
		for (int i = 0; i < 16; i++)
			push_group({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});

		// writes to undecoded indexes must leave the 2 x 1 setting alone
		settle();
		write_reg(CFG_WIDTH_GROUPS, 8'h02);
		write_reg(CFG_BLOCK_HEIGHT, 8'h01);
		write_reg(CFG_SPARE_LOW, 8'h00);
		write_reg(CFG_SPARE_HIGH, 8'hF0);
		push_group({8{8'h80}}, {8{8'h00}}, {8{8'hFF}});
		push_group({8{8'h7F}}, {8{8'h01}}, {8{8'hFE}});

		// tallest block, 1 x 128 (height written past the clamp), every pixel
		// at full difference
		settle();
		write_reg(CFG_WIDTH_GROUPS, 8'h01);
		write_reg(CFG_BLOCK_HEIGHT, 8'hFF);
		for (int i = 0; i < DEF_MAX_BLOCK_HEIGHT; i++)
			push_group({8{8'hFF}}, {8{8'h00}}, {8{8'h00}});

		// --- random, three back-pressure regimes ----------------------------
		run_traffic(333);
		source_gap_pct = 48;
		sink_stall_pct = 21;
		run_traffic(333);
		source_gap_pct = 0;
		sink_stall_pct = 0;
		run_traffic(334);

		// drain, then wait out any stray word
		settle();

		if (mismatch_count == 0 && pending_results == 0)
			$display("averaged_reference_sad_unit_test: PASS");
		else
			$display("averaged_reference_sad_unit_test: FAIL");
		$finish;
	end

endmodule
